FILE: rtl/lacm_pkg.sv
// shared types, constants and helpers for the lfsr audio channel mixer
package lacm_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 4;

  // actions carried in tuser
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_BORROW = 2'd3;

  // per-channel register numbers
  localparam logic [2:0] REG_VOLUME  = 3'd0;
  localparam logic [2:0] REG_TAPS    = 3'd1;
  localparam logic [2:0] REG_OUTPUT  = 3'd2;
  localparam logic [2:0] REG_SHIFTLO = 3'd3;
  localparam logic [2:0] REG_RELOAD  = 3'd4;
  localparam logic [2:0] REG_CTRL1   = 3'd5;
  localparam logic [2:0] REG_COUNT   = 3'd6;
  localparam logic [2:0] REG_CTRL2   = 3'd7;

  localparam logic [2:0] LINK_MODE = 3'd7;
  localparam logic [3:0] FULL_GAIN = 4'd15;

  // configuration register indexes
  localparam logic CFG_USEC   = 1'b0;
  localparam logic CFG_STEREO = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CH_START,
    ST_COUNT,
    ST_CH_OUT,
    ST_MIX,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr;
    logic add;
  } mix_ctrl_t;

  // tap select bits to shifter bit mask
  function automatic logic [11:0] map_taps(input logic [8:0] sel);
    logic [11:0] m;
    m = {6'd0, sel[5:0]};
    m[10] = sel[6];
    m[11] = sel[7];
    m[7]  = sel[8];
    return m;
  endfunction

  function automatic logic [11:0] next_shift(input logic [11:0] s, input logic [8:0] sel);
    logic fb;
    fb = ~(^(s & map_taps(sel)));
    return {s[10:0], fb};
  endfunction

endpackage

FILE: rtl/lacm_mixer.sv
// multiply-accumulate of one channel sample into the left and right sums
module lacm_mixer
  import lacm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mix_ctrl_t          ctrl_i,
  input  logic signed [7:0]  sample_i,
  input  logic [3:0]         coef_l_i,
  input  logic [3:0]         coef_r_i,
  output logic signed [13:0] left_o,
  output logic signed [13:0] right_o
);

  logic signed [13:0] left_q, left_d, right_q, right_d;
  logic signed [12:0] prod_l, prod_r;

  assign prod_l = sample_i * $signed({1'b0, coef_l_i});
  assign prod_r = sample_i * $signed({1'b0, coef_r_i});

  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    if (ctrl_i.clr) begin
      left_d  = '0;
      right_d = '0;
    end else if (ctrl_i.add) begin
      left_d  = left_q + 14'(prod_l);
      right_d = right_q + 14'(prod_r);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
    end else begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign left_o  = left_q;
  assign right_o = right_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ctrl_i.clr && ctrl_i.add))
    else $error("mixer clear and add together");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl_i.clr |=> left_o == 14'sd0)
    else $error("mixer clear did not zero left sum");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.clr && !ctrl_i.add |=> $stable(left_o) && $stable(right_o))
    else $error("mixer sums moved while idle");

endmodule

FILE: rtl/lfsr_audio_channels_mixer_unit.sv
// top level of the lfsr audio channel mixer
// Every input transfer is one action. A register write, read or external borrow
// is done on acceptance and its result is registered and posted in the next cycle.
// A sample tick walks the channels in order on the shared counter/shifter datapath.
// Each channel passes a start state (ST_CH_START) and a mix state (ST_MIX); a channel
// that is enabled also passes ST_CH_OUT to refresh its output. A counting channel on
// the time base stays in ST_COUNT for each counter decrement or underflow reload and
// leaves it once its accumulator is below the time base. ST_DONE finishes the tick.
// A counting channel normally walks about usec_per_sample/2^n decrements plus its
// underflows. Time that piles up while a channel is linked is walked off in full
// once it counts on the time base again. The block takes no new item until its
// result has been transferred out.
module lfsr_audio_channels_mixer_unit
  import lacm_pkg::*;
#(
  parameter int unsigned NumChannels = NUM_CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // reg_offset[6:0], write_data[14:7], zero
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // read_data, left_sample, right_sample, timer_borrows
);

  localparam int unsigned ChW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  state_e state_q, state_d;
  logic [ChW-1:0] ch_q;

  logic [7:0] usec_q;
  logic       stereo_q;

  logic [7:0]  vol_q     [NumChannels];
  logic [7:0]  taps_q    [NumChannels];
  logic [7:0]  outv_q    [NumChannels];
  logic [7:0]  reload_q  [NumChannels];
  logic [7:0]  ctrl1_q   [NumChannels];
  logic [7:0]  cntreg_q  [NumChannels];
  logic [3:0]  ctrl2_q   [NumChannels];
  logic [11:0] shift_q   [NumChannels];
  logic [15:0] accum_q   [NumChannels];
  logic signed [15:0] count_q [NumChannels];
  logic [7:0]  atten_q   [4];
  logic [7:0]  atten_en_q, mute_q;
  logic [7:0]  tally_q;

  logic        out_valid_q;
  logic [7:0]  out_rd_q, out_borrow_q;
  logic [13:0] out_left_q, out_right_q;

  logic s_fire, m_fire;
  logic [1:0] act;
  logic [6:0] off;
  logic [7:0] wdat;
  logic       off_ch, ch_ok;
  logic [1:0] off_ch_raw;
  logic [ChW-1:0] off_idx;
  logic [7:0] rd_data;

  logic [7:0] c1;
  logic       en, linked, ge, do_step, last_ch;
  logic [15:0] tcmp;
  logic [11:0] stepped;
  mix_ctrl_t  mix_ctrl;
  logic [3:0] coef_l, coef_r;
  logic [1:0] ch2;
  logic signed [13:0] mix_left, mix_right;

  assign act   = s_axis_tuser;
  assign off   = s_axis_tdata[6:0];
  assign wdat  = s_axis_tdata[14:7];
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  assign off_ch     = (off[6:5] == 2'b01);
  assign off_ch_raw = off[4:3];
  assign ch_ok      = ({30'd0, off_ch_raw} < NumChannels);
  assign off_idx    = ChW'(off_ch_raw);

  always_comb begin
    rd_data = '0;
    if (off_ch) begin
      if (ch_ok) begin
        case (off[2:0])
          REG_VOLUME:  rd_data = vol_q[off_idx];
          REG_TAPS:    rd_data = taps_q[off_idx];
          REG_OUTPUT:  rd_data = outv_q[off_idx];
          REG_SHIFTLO: rd_data = shift_q[off_idx][7:0];
          REG_RELOAD:  rd_data = reload_q[off_idx];
          REG_CTRL1:   rd_data = ctrl1_q[off_idx];
          REG_COUNT:   rd_data = count_q[off_idx][7:0];
          REG_CTRL2:   rd_data = {shift_q[off_idx][11:8], ctrl2_q[off_idx]};
          default:     rd_data = '0;
        endcase
      end
    end else if (off[6:2] == 5'b10000) begin
      rd_data = atten_q[off[1:0]];
    end else if (off == 7'h44) begin
      rd_data = atten_en_q;
    end else if (off == 7'h50) begin
      rd_data = mute_q;
    end
  end

  // current channel view for the tick walk
  assign c1      = ctrl1_q[ch_q];
  assign en      = c1[3];
  assign linked  = (c1[2:0] == LINK_MODE);
  assign tcmp    = 16'd1 << c1[2:0];
  assign ge      = (accum_q[ch_q] >= tcmp);
  assign stepped = next_shift(shift_q[ch_q], {c1[7], taps_q[ch_q]});
  assign last_ch = (ch_q == ChW'(NumChannels - 1));
  assign ch2     = 2'(ch_q);

  always_comb begin
    do_step = 1'b0;
    case (state_q)
      ST_CH_START: do_step = en && linked && count_q[ch_q][15];
      ST_COUNT:    do_step = ge && count_q[ch_q][15];
      default:     do_step = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (s_fire && act == ACT_TICK) state_d = ST_CH_START;
      ST_CH_START: begin
        if (!en) state_d = ST_MIX;
        else if (linked) state_d = ST_CH_OUT;
        else state_d = ST_COUNT;
      end
      ST_COUNT:    if (!ge) state_d = ST_CH_OUT;
      ST_CH_OUT:   state_d = ST_MIX;
      ST_MIX:      state_d = last_ch ? ST_DONE : ST_CH_START;
      ST_DONE:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
    mix_ctrl.clr  = s_fire && act == ACT_TICK;
    mix_ctrl.add  = (state_q == ST_MIX);
    coef_l = FULL_GAIN;
    coef_r = '0;
    if (stereo_q) begin
      coef_l = mute_q[3'd4 + 3'(ch2)] ? 4'd0
             : (atten_en_q[3'd4 + 3'(ch2)] ? atten_q[ch2][7:4] : FULL_GAIN);
      coef_r = mute_q[3'(ch2)] ? 4'd0
             : (atten_en_q[3'(ch2)] ? atten_q[ch2][3:0] : FULL_GAIN);
    end
  end

  lacm_mixer u_mixer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mix_ctrl),
    .sample_i ($signed(outv_q[ch_q])),
    .coef_l_i (coef_l),
    .coef_r_i (coef_r),
    .left_o   (mix_left),
    .right_o  (mix_right)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ch_q     <= '0;
      usec_q   <= 8'd22;
      stereo_q <= 1'b1;
      for (int i = 0; i < NumChannels; i++) begin
        vol_q[i]    <= '0;
        taps_q[i]   <= '0;
        outv_q[i]   <= '0;
        reload_q[i] <= '0;
        ctrl1_q[i]  <= '0;
        cntreg_q[i] <= '0;
        ctrl2_q[i]  <= '0;
        shift_q[i]  <= '0;
        accum_q[i]  <= '0;
        count_q[i]  <= '0;
      end
      for (int i = 0; i < 4; i++) atten_q[i] <= '0;
      atten_en_q   <= '0;
      mute_q       <= '0;
      tally_q      <= '0;
      out_valid_q  <= 1'b0;
      out_rd_q     <= '0;
      out_left_q   <= '0;
      out_right_q  <= '0;
      out_borrow_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_USEC) usec_q <= cfg_wdata_i;
        else stereo_q <= cfg_wdata_i[0];
      end
      if (m_fire) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            ch_q    <= '0;
            tally_q <= '0;
            if (act != ACT_TICK) begin
              out_valid_q  <= 1'b1;
              out_rd_q     <= (act == ACT_READ) ? rd_data : 8'd0;
              out_left_q   <= '0;
              out_right_q  <= '0;
              out_borrow_q <= '0;
            end
            if (act == ACT_WRITE && off_ch && ch_ok) begin
              case (off[2:0])
                REG_VOLUME:  vol_q[off_idx]    <= wdat;
                REG_TAPS:    taps_q[off_idx]   <= wdat;
                REG_OUTPUT:  outv_q[off_idx]   <= wdat;
                REG_SHIFTLO: shift_q[off_idx][7:0] <= wdat;
                REG_RELOAD:  reload_q[off_idx] <= wdat;
                REG_CTRL1:   ctrl1_q[off_idx]  <= wdat;
                REG_COUNT:   cntreg_q[off_idx] <= wdat;
                REG_CTRL2:   begin
                  ctrl2_q[off_idx] <= wdat[3:0];
                  shift_q[off_idx][11:8] <= wdat[7:4];
                end
                default:     ;
              endcase
            end else if (act == ACT_WRITE && off[6:2] == 5'b10000) begin
              atten_q[off[1:0]] <= wdat;
            end else if (act == ACT_WRITE && off == 7'h44) begin
              atten_en_q <= wdat;
            end else if (act == ACT_WRITE && off == 7'h50) begin
              mute_q <= wdat;
            end else if (act == ACT_BORROW) begin
              if (!(ctrl1_q[0][3] && ctrl1_q[0][2:0] != LINK_MODE)
                  && count_q[0] != 16'sh8000)
                count_q[0] <= count_q[0] - 16'sd1;
            end
          end
        end
        ST_CH_START: begin
          if (!en) begin
            accum_q[ch_q] <= '0;
            count_q[ch_q] <= '0;
          end else begin
            accum_q[ch_q] <= accum_q[ch_q] + {8'd0, usec_q};
            if (do_step) count_q[ch_q] <= count_q[ch_q] + $signed({8'd0, cntreg_q[ch_q]});
          end
        end
        ST_COUNT: begin
          if (ge && !count_q[ch_q][15]) begin
            accum_q[ch_q] <= accum_q[ch_q] - tcmp;
            count_q[ch_q] <= count_q[ch_q] - 16'sd1;
          end else if (ge) begin
            count_q[ch_q] <= $signed({8'd0, cntreg_q[ch_q]});
          end
        end
        ST_CH_OUT: begin
          if (!c1[5]) outv_q[ch_q] <= shift_q[ch_q][0] ? 8'd0 - vol_q[ch_q] : vol_q[ch_q];
        end
        ST_MIX: begin
          if (!last_ch) ch_q <= ch_q + 1'b1;
        end
        ST_DONE: begin
          out_valid_q  <= 1'b1;
          out_rd_q     <= '0;
          out_left_q   <= mix_left;
          out_right_q  <= mix_right;
          out_borrow_q <= tally_q;
        end
        default: ;
      endcase

      // shifter step with its borrow into the next channel, or into the borrow tally from the last one
      if (do_step) begin
        shift_q[ch_q] <= stepped;
        if (c1[5]) outv_q[ch_q] <= stepped[0] ? outv_q[ch_q] + vol_q[ch_q]
                                              : outv_q[ch_q] - vol_q[ch_q];
        if (last_ch) begin
          if (tally_q != 8'hFF) tally_q <= tally_q + 8'd1;
        end else begin
          for (int k = 1; k < NumChannels; k++) begin
            if (k == int'(ch_q) + 1) begin
              if (!(ctrl1_q[k][3] && ctrl1_q[k][2:0] != LINK_MODE)
                  && count_q[k] != 16'sh8000)
                count_q[k] <= count_q[k] - 16'sd1;
            end
          end
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_borrow_q, out_right_q, out_left_q, out_rd_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !out_valid_q)
    else $error("result pending while a tick is in progress");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COUNT |-> en && !linked)
    else $error("counting walk on a disabled or linked channel");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("ready right after an accepted transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |=> out_valid_q && state_q == ST_IDLE)
    else $error("tick result not posted");

endmodule

FILE: tb/sv/testbench.sv
// testbench for the lfsr audio channel mixer: directed and random stream traffic against a predictor
module testbench;
  import lacm_pkg::*;

  // fields from the top bit down, so read_data sits in the low bits
  typedef struct packed {
    logic [7:0]  borrows;
    logic [13:0] right;
    logic [13:0] left;
    logic [7:0]  rd;
  } mix_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // reg_offset[6:0], write_data[14:7], zero
  logic [1:0]  s_axis_tuser;   // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // read_data, left_sample, right_sample, timer_borrows

  lfsr_audio_channels_mixer_unit dut (.*);

  // predictor state
  logic [7:0]  chan_regs [32];
  logic [7:0]  atten [4];
  logic [8:0]  taps [4];
  logic [11:0] shifter [4];
  logic [15:0] accum [4];
  int          count [4];
  logic [7:0]  atten_en;
  logic [7:0]  mute;
  int          tally;
  logic [7:0]  usec;
  logic        stereo;

  mix_result_t expected_q[$];
  int          errors;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50000000;
    $display("simulation failed");
    $finish;
  end

  task automatic borrow_into(input int ch);
    logic [7:0] c1;
    c1 = chan_regs[ch*8+5];
    if (c1[3] && c1[2:0] != LINK_MODE) return;
    if (count[ch] > -32768) count[ch]--;
  endtask

  task automatic shift_channel(input int ch);
    logic [11:0] m;
    logic [11:0] s;
    m = {6'd0, taps[ch][5:0]};
    m[10] = taps[ch][6];
    m[11] = taps[ch][7];
    m[7]  = taps[ch][8];
    s = {shifter[ch][10:0], ~(^(shifter[ch] & m))};
    shifter[ch] = s;
    if (chan_regs[ch*8+5][5]) begin
      if (s[0]) chan_regs[ch*8+2] = chan_regs[ch*8+2] + chan_regs[ch*8];
      else chan_regs[ch*8+2] = chan_regs[ch*8+2] - chan_regs[ch*8];
    end
    if (ch < NUM_CHANNELS_DEF - 1) borrow_into(ch + 1);
    else if (tally < 255) tally++;
  endtask

  task automatic run_channel(input int ch);
    logic [7:0] c1;
    int t;
    c1 = chan_regs[ch*8+5];
    if (!c1[3]) begin
      accum[ch] = '0;
      count[ch] = 0;
      return;
    end
    accum[ch] = accum[ch] + usec;
    if (c1[2:0] == LINK_MODE) begin
      if (count[ch] < 0) begin
        count[ch] += int'(chan_regs[ch*8+6]);
        shift_channel(ch);
      end
    end else begin
      t = 1 << c1[2:0];
      forever begin
        while (accum[ch] >= t && count[ch] >= 0) begin
          accum[ch] = accum[ch] - t[15:0];
          count[ch]--;
        end
        if (accum[ch] < t) break;
        count[ch] = int'(chan_regs[ch*8+6]);
        shift_channel(ch);
      end
    end
    if (!chan_regs[ch*8+5][5])
      chan_regs[ch*8+2] = shifter[ch][0] ? 8'd0 - chan_regs[ch*8] : chan_regs[ch*8];
  endtask

  task automatic predict_mix(input logic [1:0] act, input logic [6:0] off, input logic [7:0] d);
    mix_result_t r;
    int left, right, v, ch;
    logic [2:0] rg;
    left = 0;
    right = 0;
    r = '0;
    ch = int'(off[4:3]);
    rg = off[2:0];
    case (act)
      ACT_TICK: begin
        tally = 0;
        for (int j = 0; j < NUM_CHANNELS_DEF; j++) begin
          run_channel(j);
          v = int'($signed(chan_regs[j*8+2]));
          if (!stereo) begin
            left += v * 15;
          end else begin
            if (!mute[4+j]) left += atten_en[4+j] ? v * int'(atten[j][7:4]) : v * 15;
            if (!mute[j]) right += atten_en[j] ? v * int'(atten[j][3:0]) : v * 15;
          end
        end
        r.left = left[13:0];
        r.right = right[13:0];
        r.borrows = tally[7:0];
      end
      ACT_WRITE: begin
        if (off >= 7'h20 && off < 7'h40) begin
          chan_regs[ch*8+rg] = d;
          if (rg == REG_SHIFTLO) shifter[ch][7:0] = d;
          else if (rg == REG_CTRL2) shifter[ch][11:8] = d[7:4];
          else if (rg == REG_TAPS || rg == REG_CTRL1)
            taps[ch] = {chan_regs[ch*8+5][7], chan_regs[ch*8+1]};
        end else if (off >= 7'h40 && off <= 7'h43) begin
          atten[off[1:0]] = d;
        end else if (off == 7'h44) begin
          atten_en = d;
        end else if (off == 7'h50) begin
          mute = d;
        end
      end
      ACT_READ: begin
        if (off >= 7'h20 && off < 7'h40) begin
          if (rg == REG_SHIFTLO) r.rd = shifter[ch][7:0];
          else if (rg == REG_COUNT) r.rd = count[ch][7:0];
          else if (rg == REG_CTRL2) r.rd = {shifter[ch][11:8], chan_regs[ch*8+7][3:0]};
          else r.rd = chan_regs[ch*8+rg];
        end else if (off >= 7'h40 && off <= 7'h43) r.rd = atten[off[1:0]];
        else if (off == 7'h44) r.rd = atten_en;
        else if (off == 7'h50) r.rd = mute;
      end
      default: borrow_into(0);
    endcase
    expected_q.push_back(r);
  endtask

  task automatic send_item(input logic [1:0] act, input logic [6:0] off, input logic [7:0] d);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {1'b0, d, off};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_mix(act, off, d);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] val);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_USEC) usec = val;
    else stereo = val[0];
  endtask

  // result checker and receiver back-pressure
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    mix_result_t got, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[43:0];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.rd != exp_r.rd) begin
          $display("%0t: read_data exp %h got %h", $realtime, exp_r.rd, got.rd);
          errors++;
        end
        if (got.left != exp_r.left) begin
          $display("%0t: left_sample exp %h got %h", $realtime, exp_r.left, got.left);
          errors++;
        end
        if (got.right != exp_r.right) begin
          $display("%0t: right_sample exp %h got %h", $realtime, exp_r.right, got.right);
          errors++;
        end
        if (got.borrows != exp_r.borrows) begin
          $display("%0t: timer_borrows exp %h got %h", $realtime, exp_r.borrows,
                   got.borrows);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(ACT_WRITE, 7'h20, 8'h7F);   // ch0 volume
    send_item(ACT_WRITE, 7'h21, 8'hFF);   // all taps
    send_item(ACT_WRITE, 7'h23, 8'hA5);
    send_item(ACT_WRITE, 7'h27, 8'hF3);   // shifter high bits
    send_item(ACT_WRITE, 7'h26, 8'h02);
    send_item(ACT_WRITE, 7'h25, 8'h88);   // enabled, 1 us base, tap bit 8
    send_item(ACT_TICK, 7'h00, 8'h00);
    send_item(ACT_READ, 7'h23, 8'h00);
    send_item(ACT_READ, 7'h26, 8'h00);
    send_item(ACT_READ, 7'h27, 8'h00);
    send_item(ACT_WRITE, 7'h28, 8'h80);   // ch1 volume
    send_item(ACT_WRITE, 7'h2D, 8'h2F);   // linked, integrate
    send_item(ACT_WRITE, 7'h3D, 8'h0F);   // ch3 linked, counts to timer
    send_item(ACT_WRITE, 7'h35, 8'h0F);
    send_item(ACT_BORROW, 7'h00, 8'h00);
    send_item(ACT_WRITE, 7'h41, 8'h3C);
    send_item(ACT_WRITE, 7'h44, 8'hFF);
    send_item(ACT_WRITE, 7'h50, 8'h28);
    send_item(ACT_TICK, 7'h7F, 8'hFF);
    send_item(ACT_READ, 7'h41, 8'h00);
    send_item(ACT_READ, 7'h44, 8'h00);
    send_item(ACT_READ, 7'h50, 8'h00);
    send_item(ACT_WRITE, 7'h7F, 8'hFF);   // unmapped write
    send_item(ACT_READ, 7'h00, 8'h00);    // unmapped read
    send_item(ACT_TICK, 7'h00, 8'h00);
  endtask

  task automatic random_item();
    int k;
    logic [6:0] off;
    logic [7:0] d;
    k = $urandom_range(99);
    off = {2'b01, 5'($urandom_range(31))};
    d = 8'($urandom_range(255));
    if (k < 40) begin
      send_item(ACT_TICK, 7'($urandom_range(127)), 8'($urandom_range(255)));
    end else if (k < 50 && off[2:0] == REG_CTRL1) begin
      // keep channels enabled, counting on a random time base or linked
      send_item(ACT_WRITE, off, {d[7:4], 1'b1, 3'($urandom_range(7))});
    end else if (k < 70) begin
      send_item(ACT_WRITE, off, d);
    end else if (k < 76) begin
      send_item(ACT_WRITE, $urandom_range(1) ? 7'h44 : 7'h50, d);
    end else if (k < 80) begin
      send_item(ACT_WRITE, 7'h40 + 7'($urandom_range(3)), d);
    end else if (k < 90) begin
      send_item(ACT_READ, 7'($urandom_range(127)), d);
    end else if (k < 95) begin
      send_item(ACT_BORROW, 7'($urandom_range(127)), d);
    end else begin
      send_item(ACT_WRITE, 7'($urandom_range(127)), d);
    end
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) hold_cycles = 400;   // receiver stalls while sender keeps offering
      if (i == n / 2) wait_drained();
      random_item();
    end
  endtask

  task automatic test_config();
    write_cfg(CFG_USEC, 8'd1);
    write_cfg(CFG_STEREO, 8'd0);
    test_random(30);
    write_cfg(CFG_USEC, 8'd255);
    test_random(30);
    write_cfg(CFG_STEREO, 8'd1);
    write_cfg(CFG_USEC, 8'd22);
  endtask

  initial begin
    for (int i = 0; i < 32; i++) chan_regs[i] = '0;
    for (int i = 0; i < 4; i++) begin
      atten[i] = '0; taps[i] = '0; shifter[i] = '0; accum[i] = '0; count[i] = 0;
    end
    atten_en = '0; mute = '0; tally = 0; usec = 8'd22; stereo = 1'b1;
    errors = 0; hold_cycles = 0;
    send_idle_pct = 23; recv_idle_pct = 70;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = 1'b0; cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(150);
    test_config();
    send_idle_pct = 70; recv_idle_pct = 23;
    write_cfg(CFG_USEC, 8'($urandom_range(255, 1)));
    test_random(150);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_cfg(CFG_USEC, 8'd40);
    test_random(200);
    wait_drained();
    repeat (100) @(negedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/lacm_pkg.sv
rtl/lacm_mixer.sv
rtl/lfsr_audio_channels_mixer_unit.sv
tb/sv/testbench.sv
